// File: rtl/bta_pkg.sv
// Shared types and constants for the block table allocator.
// No dependencies; imported by block_table_allocator_unit, bta_checker and the testbench.
package bta_pkg;

	localparam int NUM_BLOCKS  = 1024;
	localparam int BLOCK_BYTES = 32;    // power of two
	localparam int BB_SH       = $clog2(BLOCK_BYTES);
	localparam int IDX_W       = $clog2(NUM_BLOCKS);
	localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
	localparam int SIZE_W      = 16;
	localparam int OFFS_W      = 16;
	localparam int BOFF_W      = 15;
	localparam int NEED_W      = SIZE_W + 1;

	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BLOCKS - 1);
	localparam logic [31:0]      POOL_BYTES = 32'(NUM_BLOCKS * BLOCK_BYTES);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOC_OK   = 2'd0,
		ST_ALLOC_FAIL = 2'd1,
		ST_FREED      = 2'd2,
		ST_OUTSIDE    = 2'd3
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [SIZE_W-1:0] size;
		logic [OFFS_W-1:0] offset;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [BOFF_W-1:0] byte_offset;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_FREE_RD,
		S_FREE_CLR,
		S_RESP
	} state_t;

endpackage

// File: rtl/bta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bta_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/block_table_allocator_unit.sv
// Block table allocator: allocate scans the table top-down, one entry a cycle.
// Allocate: a scan over the registered table read, then one mark write per
// block of the found run, then the output register.
// Free: a table read, one clear write per cleared block, then the output register.
// One request in flight; next accepted while the previous beat waits.
// After reset a clearing pass writes NUM_BLOCKS entries with req_ready low.
module block_table_allocator_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bta_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bta_pkg::rsp_t rsp
);
	import bta_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0]  wr_addr_q;
	logic [IDX_W-1:0]  scan_addr_q;
	logic [IDX_W-1:0]  data_idx_s1;
	logic              rd_vld_s1;
	logic              scan_done_q;
	logic [CNT_W-1:0]  need_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  cnt_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              ram_we;
	logic [CNT_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [CNT_W-1:0]  ram_rdata;

	logic [NEED_W-1:0] need_full;
	logic              outside;
	logic [IDX_W-1:0]  free_idx;
	logic              accept;
	logic              alloc_bad;
	logic [CNT_W-1:0]  run_nx;
	logic              hit;
	logic              miss;
	logic              rsp_load;
	logic [31:0]       hit_bytes;

	bta_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign need_full = (NEED_W'(req.size) + NEED_W'(BLOCK_BYTES - 1)) >> BB_SH;
	assign outside   = {16'd0, req.offset} >= POOL_BYTES;
	assign free_idx  = IDX_W'(req.offset >> BB_SH);
	assign alloc_bad = (req.size == '0) || (need_full > NEED_W'(NUM_BLOCKS));
	assign accept    = req_valid && req_ready;

	assign run_nx    = (ram_rdata == '0) ? run_q + CNT_W'(1) : '0;
	assign hit       = rd_vld_s1 && (run_nx == need_q);
	assign miss      = rd_vld_s1 && !hit && (data_idx_s1 == '0);
	assign hit_bytes = 32'(data_idx_s1) << BB_SH;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// idle reads at the free index so the entry is ready in S_FREE_RD
	assign ram_raddr = (state_q == S_SCAN) ? scan_addr_q : free_idx;
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_MARK) ||
	                   (state_q == S_FREE_CLR);
	assign ram_wdata = (state_q == S_MARK) ? need_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (wr_addr_q == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					if (req.op == OP_FREE) begin
						state_d = outside ? S_RESP : S_FREE_RD;
					end else begin
						state_d = alloc_bad ? S_RESP : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) state_d = S_MARK;
				else if (miss) state_d = S_RESP;
			end
			S_MARK: begin
				if (cnt_q == CNT_W'(1)) state_d = S_RESP;
			end
			S_FREE_RD: begin
				state_d = (ram_rdata == '0) ? S_RESP : S_FREE_CLR;
			end
			S_FREE_CLR: begin
				if (cnt_q == CNT_W'(1) || wr_addr_q == LAST_IDX) state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			scan_done_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR, S_MARK, S_FREE_CLR: begin
					wr_addr_q <= wr_addr_q + IDX_W'(1);
				end
				S_IDLE: begin
					scan_done_q <= 1'b0;
					if (accept) wr_addr_q <= free_idx;
				end
				S_SCAN: begin
					rd_vld_s1 <= !scan_done_q && !hit && !miss;
					if (scan_addr_q == '0) scan_done_q <= 1'b1;
					if (hit) wr_addr_q <= data_idx_s1;
				end
				S_FREE_RD, S_RESP: begin
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= res_q;
		unique case (state_q)
			S_IDLE: begin
				scan_addr_q <= LAST_IDX;
				run_q       <= '0;
				need_q      <= CNT_W'(need_full);
				res_q.byte_offset <= '0;
				if (req.op == OP_FREE) begin
					res_q.status <= outside ? ST_OUTSIDE : ST_FREED;
				end else begin
					res_q.status <= ST_ALLOC_FAIL;
				end
			end
			S_SCAN: begin
				scan_addr_q <= scan_addr_q - IDX_W'(1);
				data_idx_s1 <= scan_addr_q;
				if (rd_vld_s1) run_q <= run_nx;
				if (hit) begin
					cnt_q             <= need_q;
					res_q.status      <= ST_ALLOC_OK;
					res_q.byte_offset <= hit_bytes[BOFF_W-1:0];
				end
			end
			S_FREE_RD: begin
				cnt_q <= ram_rdata;
			end
			S_MARK, S_FREE_CLR: begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_CLEAR, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !ram_we)
		else $error("table written during scan");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted beat did not start work");

	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK || state_q == S_FREE_CLR) |-> (cnt_q != '0))
		else $error("write pass with zero count");

	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_ALLOC_OK) |-> (rsp.byte_offset[BB_SH-1:0] == '0))
		else $error("allocated offset not block aligned");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_ALLOC_OK) |-> (rsp.byte_offset == '0))
		else $error("nonzero offset on non-allocation beat");
`endif

endmodule

// File: dv/bta_checker.sv
`timescale 1ns / 1ps
// Response checker for block_table_allocator_unit: keeps its own block table,
// predicts a response for every request beat and compares every response beat.
// Depends on bta_pkg.
module bta_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  bta_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  bta_pkg::rsp_t rsp,
	output int            fail_cnt,
	output int            pending
);
	import bta_pkg::*;

	logic [CNT_W-1:0] blk_cnt [NUM_BLOCKS];
	rsp_t             rsp_q [$];
	rsp_t             want;

	// top-down search for the first run of free blocks long enough
	function automatic rsp_t alloc_blocks(input logic [SIZE_W-1:0] bytes);
		rsp_t r;
		int   need;
		int   run;
		r.status      = ST_ALLOC_FAIL;
		r.byte_offset = '0;
		if (bytes == '0)
			return r;
		need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
		run  = 0;
		for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
			if (blk_cnt[b] == '0)
				run++;
			else
				run = 0;
			if (run == need) begin
				for (int k = 0; k < need; k++)
					blk_cnt[b + k] = CNT_W'(need);
				r.status      = ST_ALLOC_OK;
				r.byte_offset = BOFF_W'(b * BLOCK_BYTES);
				return r;
			end
		end
		return r;
	endfunction

	// clears the addressed block's count worth of entries, upward, clipped at the top
	function automatic rsp_t free_blocks(input logic [OFFS_W-1:0] offs);
		rsp_t r;
		int   idx;
		int   n;
		r.status      = ST_OUTSIDE;
		r.byte_offset = '0;
		if (int'(offs) >= NUM_BLOCKS * BLOCK_BYTES)
			return r;
		idx = int'(offs) / BLOCK_BYTES;
		n   = int'(blk_cnt[idx]);
		for (int k = 0; k < n && idx + k < NUM_BLOCKS; k++)
			blk_cnt[idx + k] = '0;
		r.status = ST_FREED;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (blk_cnt[i])
				blk_cnt[i] = '0;
			rsp_q.delete();
			fail_cnt = 0;
			pending  = 0;
		end else begin
			// response first: a request taken on the same edge belongs behind it
			if (rsp_valid && rsp_ready) begin
				if (rsp_q.size() == 0) begin
					$display("%0t: response beat with nothing outstanding: %s%0d %s%0d",
						$time, "status=", rsp.status, "byte_offset=", rsp.byte_offset);
					fail_cnt++;
				end else begin
					want = rsp_q.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, rsp.status);
						fail_cnt++;
					end
					if (rsp.byte_offset !== want.byte_offset) begin
						$display("%0t: byte_offset mismatch: expected %0d, got %0d",
							$time, want.byte_offset, rsp.byte_offset);
						fail_cnt++;
					end
				end
			end
			if (req_valid && req_ready)
				rsp_q.push_back(req.op == OP_ALLOC ? alloc_blocks(req.size)
					: free_blocks(req.offset));
			pending = rsp_q.size();
		end
	end

endmodule

// File: dv/tb_block_table_allocator_unit.sv
`timescale 1ns / 1ps
// Testbench top for block_table_allocator_unit: directed and random allocate/free
// traffic with bursty requests and a stalling response side. Depends on bta_pkg
// and bta_checker.
module tb_block_table_allocator_unit;
	import bta_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int RAND_ITEMS = 560;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fail_cnt;
	int pending;
	int idle_cycles = 0;
	int stall_left  = 0;
	int rx_mode     = 0;
	int mode_left   = 0;
	int live_offs [$];    // byte offsets handed out and not yet freed

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	block_table_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	bta_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.fail_cnt  (fail_cnt),
		.pending   (pending)
	);

	// ignored fields carry random junk
	function automatic req_t alloc_req(input int bytes);
		req_t r;
		r.op     = OP_ALLOC;
		r.size   = SIZE_W'(bytes);
		r.offset = OFFS_W'($urandom);
		return r;
	endfunction

	function automatic req_t free_req(input int offs);
		req_t r;
		r.op     = OP_FREE;
		r.size   = SIZE_W'($urandom);
		r.offset = OFFS_W'(offs);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken,
	// valid still high
	task automatic send(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	always @(posedge clk)
		if (rsp_valid && rsp_ready && rsp.status == ST_ALLOC_OK)
			live_offs.push_back(int'(rsp.byte_offset));

	// response side: always ready, coin flips, or rare long stalls
	always @(negedge clk) begin
		if (mode_left == 0) begin
			rx_mode   = $urandom_range(0, 2);
			mode_left = $urandom_range(100, 2000);
		end else begin
			mode_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(1, 20);
						rsp_ready <= 1'b0;
					end else begin
						rsp_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_t r;
		int   pick;
		int   slot;
		int   offs;
		int   bytes;
		int   gap;
		int   burst_left;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: boundaries, whole pool, partial and clipped frees
		send(free_req(0));                              // free of a free block
		send(alloc_req(NUM_BLOCKS * BLOCK_BYTES));      // whole pool
		send(alloc_req(1));                             // no room
		send(free_req(0));
		send(alloc_req(0));                             // zero size
		send(alloc_req(65535));                         // larger than the pool
		send(alloc_req(1));
		send(alloc_req(BLOCK_BYTES));
		send(alloc_req(BLOCK_BYTES + 1));
		send(alloc_req(100));
		send(free_req(NUM_BLOCKS * BLOCK_BYTES - 1));   // last byte of the pool
		send(free_req(NUM_BLOCKS * BLOCK_BYTES));       // first byte outside
		send(free_req(65535));
		send(free_req(1021 * BLOCK_BYTES + 5));         // inside a two-block run
		send(free_req(1022 * BLOCK_BYTES));
		send(alloc_req(2 * BLOCK_BYTES));
		send(free_req(1023 * BLOCK_BYTES));             // count runs past the top
		send(free_req(1020 * BLOCK_BYTES));
		send(free_req(1016 * BLOCK_BYTES));
		send(free_req(1022 * BLOCK_BYTES));
		send(alloc_req((NUM_BLOCKS - 1) * BLOCK_BYTES));
		send(alloc_req(BLOCK_BYTES));                   // only block 0 left
		send(free_req(0));
		send(free_req(BLOCK_BYTES));
		drain();
		live_offs.delete();

		burst_left = $urandom_range(1, 30);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				r.op     = op_t'($urandom_range(0, 1));
				r.size   = SIZE_W'($urandom);
				r.offset = OFFS_W'($urandom);
			end else if (live_offs.size() != 0 && pick < (live_offs.size() > 24 ? 75 : 45)) begin
				slot = $urandom_range(0, live_offs.size() - 1);
				if ($urandom_range(0, 4) == 0) begin
					// somewhere inside or just past the allocation; keep its base for later
					offs = live_offs[slot] + BLOCK_BYTES * $urandom_range(0, 3)
						+ $urandom_range(0, BLOCK_BYTES - 1);
				end else begin
					offs = live_offs[slot];
					live_offs.delete(slot);
				end
				r = free_req(offs);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					bytes = $urandom_range(1, 256);
				else if (pick < 95)
					bytes = $urandom_range(257, 4096);
				else if (pick < 98)
					bytes = $urandom_range(0, 65535);
				else
					bytes = 0;
				r = alloc_req(bytes);
			end
			send(r);
			burst_left--;
			if (n == RAND_ITEMS / 2) begin
				drain();
			end else if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 30);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				if (gap != 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
		drain();
		repeat (40) @(negedge clk);

		if (fail_cnt == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
